/* rtl/core/ptatamb_pkg.sv */
// Shared constants and types for the PTAT ambient temperature block.
// Used by ptatamb_datapath and ptat_ambient_temperature; depends on nothing.
package ptatamb_pkg;

   localparam int FRAC_BITS = 16;

   localparam int IN_W   = 16;
   localparam int TEMP_W = 18;
   localparam int KV_W   = 6;
   localparam int KT_W   = 10;
   localparam int SLP_W  = 16;
   localparam int D2_W   = 22;
   localparam int BASE_W = 6;

   localparam int DV_W   = 16 + FRAC_BITS;
   localparam int VART_W = 36 + FRAC_BITS;
   localparam int DEN_W  = 10 + FRAC_BITS;
   localparam int QM_W   = 24 + FRAC_BITS;
   localparam int Q_SW   = QM_W + 2;
   localparam int T_SW   = QM_W + 3;
   localparam int TN_W   = T_SW - 1 + 3;
   localparam int TOT_W  = TN_W + 2;

   localparam int LAT = VART_W + QM_W + TN_W + 11;

   localparam int TEMP_MAX = 131071;
   localparam int TEMP_MIN = -131072;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_KV_KT    = 3'd0,
      REG_PTAT25   = 3'd1,
      REG_ALPHA    = 3'd2,
      REG_SUPPLY25 = 3'd3,
      REG_SLOPE    = 3'd4,
      REG_BASE     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [15:0]       kv_kt;
      logic [15:0]       ptat25;
      logic [3:0]        alpha;
      logic [15:0]       supply25;
      logic [15:0]       slope;
      logic [BASE_W-1:0] base;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              err;
   } result_type;

endpackage

/* rtl/core/ptat_ambient_temperature.sv */
// Top level of the PTAT ambient temperature block: calibration registers,
// output register with skid stage, and the datapath. Depends on ptatamb_pkg.
//
// Each accepted beat of supply, PTAT and Vbe readings gives one result beat
// with the ambient temperature in 1/256 degree and an error flag. The block
// takes one beat per clock while req_stall is low (skid stage empty); most
// of the pipeline depth lies in the three divider chains, which each retire
// one quotient bit per pipeline stage. Calibration registers must only be
// written while no beat is in flight.
module ptat_ambient_temperature
   import ptatamb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [IN_W-1:0]   req_supply_raw,
   input  logic signed [IN_W-1:0]   req_ptat_raw,
   input  logic signed [IN_W-1:0]   req_vbe_raw,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_ambient_temp,
   output logic                     rsp_calc_error,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   logic [15:0]       kv_kt_ff, ptat25_ff, supply25_ff, slope_ff;
   logic [3:0]        alpha_ff;
   logic [BASE_W-1:0] base_ff;
   cfg_type           cfg;
   reg_idx_type       idx;
   logic              wr;

   logic              en;
   logic              dp_valid;
   result_type        dp_res;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              skid_vld_ff, skid_vld_in;
   result_type        skid_ff, skid_in;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_kt_ff    <= '0;
         ptat25_ff   <= '0;
         alpha_ff    <= '0;
         supply25_ff <= '0;
         slope_ff    <= 16'd1;
         base_ff     <= BASE_W'(25);
      end else if (wr) begin
         unique case (idx)
            REG_KV_KT:    kv_kt_ff    <= pwdata[15:0];
            REG_PTAT25:   ptat25_ff   <= pwdata[15:0];
            REG_ALPHA:    alpha_ff    <= pwdata[3:0];
            REG_SUPPLY25: supply25_ff <= pwdata[15:0];
            REG_SLOPE:    slope_ff    <= pwdata[15:0];
            REG_BASE:     base_ff     <= pwdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KV_KT:    prdata = DATA_W'(kv_kt_ff);
         REG_PTAT25:   prdata = DATA_W'(ptat25_ff);
         REG_ALPHA:    prdata = DATA_W'(alpha_ff);
         REG_SUPPLY25: prdata = DATA_W'(supply25_ff);
         REG_SLOPE:    prdata = DATA_W'(slope_ff);
         REG_BASE:     prdata = DATA_W'(base_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.kv_kt    = kv_kt_ff;
   assign cfg.ptat25   = ptat25_ff;
   assign cfg.alpha    = alpha_ff;
   assign cfg.supply25 = supply25_ff;
   assign cfg.slope    = slope_ff;
   assign cfg.base     = base_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   ptatamb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_supply (req_supply_raw),
      .in_ptat   (req_ptat_raw),
      .in_vbe    (req_vbe_raw),
      .out_valid (dp_valid),
      .out_res   (dp_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      skid_vld_in  = skid_vld_ff;
      skid_in      = skid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = skid_ff;
            skid_vld_in  = 1'b0;
         end else begin
            rsp_valid_in = en && dp_valid;
            rsp_in       = dp_res;
         end
      end else if (en && dp_valid) begin
         skid_vld_in = 1'b1;
         skid_in     = dp_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_vld_ff  <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ambient_temp = rsp_ff.temp;
   assign rsp_calc_error   = rsp_ff.err;

   a_skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("Skid stage holds a beat while the output register is empty.");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_stall) |=> (!skid_vld_ff && rsp_valid_ff))
      else $error("Skid stage did not move into the output register.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && skid_vld_ff) |=> skid_vld_ff)
      else $error("Skid stage lost a beat while the output was stalled.");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_stall) |=> $stable(rsp_ff) && $stable(skid_ff))
      else $error("Held beats changed while the output was stalled.");

endmodule

/* rtl/core/ptatamb_datapath.sv */
// Pipelined fixed-point ambient temperature datapath: three restoring divider
// chains, one quotient bit per stage (the first chain does two divisions),
// with a multiply and fix-up stages between them. Depends on ptatamb_pkg.
module ptatamb_datapath
   import ptatamb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   input  logic [IN_W-1:0]         in_supply,
   input  logic [IN_W-1:0]         in_ptat,
   input  logic [IN_W-1:0]         in_vbe,
   output logic                    out_valid,
   output result_type              out_res
);

   typedef struct packed {
      logic              err;
      logic              vneg;
      logic              dneg;
      logic [D2_W-1:0]   vrem;
      logic [VART_W-1:0] vdq;
      logic [D2_W-1:0]   vden;
      logic [SLP_W-1:0]  drem;
      logic [DV_W-1:0]   ddq;
   } a_type;

   typedef struct packed {
      logic                 err;
      logic                 vneg;
      logic [VART_W-1:0]    vmag;
      logic                 pneg;
      logic [DV_W+KV_W-1:0] pmag;
   } m1_type;

   typedef struct packed {
      logic              err;
      logic              vneg;
      logic [VART_W-1:0] vmag;
      logic [DEN_W:0]    den;
   } m2_type;

   typedef struct packed {
      logic             err;
      logic             qneg;
      logic             ovf;
      logic [DEN_W-1:0] brem;
      logic [QM_W-1:0]  bdq;
      logic [DEN_W-1:0] bden;
   } b_type;

   typedef struct packed {
      logic            err;
      logic [Q_SW-1:0] qs;
   } t1_type;

   typedef struct packed {
      logic            err;
      logic [T_SW-1:0] t;
   } t2_type;

   typedef struct packed {
      logic            err;
      logic            cneg;
      logic [KT_W-1:0] crem;
      logic [TN_W-1:0] cdq;
   } c_type;

   typedef struct packed {
      logic             err;
      logic [TOT_W-1:0] v;
   } e_type;

   localparam logic [DEN_W:0]   ONE_DEN = (DEN_W+1)'(1) << FRAC_BITS;
   localparam logic [TOT_W-1:0] RND     = (TOT_W'(1) << (FRAC_BITS - 8)) - TOT_W'(1);
   localparam logic signed [TOT_W-1:0] RES_MAX = TOT_W'(TEMP_MAX);
   localparam logic signed [TOT_W-1:0] RES_MIN = TOT_W'(TEMP_MIN);

   function automatic a_type a_step(a_type s, logic do_dv, logic [SLP_W-1:0] smag);
      logic [D2_W:0]  vt;
      logic [SLP_W:0] dt;
      a_type          r;
      r  = s;
      vt = {s.vrem, s.vdq[VART_W-1]};
      if (vt >= {1'b0, s.vden}) begin
         r.vrem = D2_W'(vt - {1'b0, s.vden});
         r.vdq  = {s.vdq[VART_W-2:0], 1'b1};
      end else begin
         r.vrem = vt[D2_W-1:0];
         r.vdq  = {s.vdq[VART_W-2:0], 1'b0};
      end
      dt = {s.drem, s.ddq[DV_W-1]};
      if (do_dv) begin
         if (dt >= {1'b0, smag}) begin
            r.drem = SLP_W'(dt - {1'b0, smag});
            r.ddq  = {s.ddq[DV_W-2:0], 1'b1};
         end else begin
            r.drem = dt[SLP_W-1:0];
            r.ddq  = {s.ddq[DV_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic b_type b_step(b_type s);
      logic [DEN_W:0] bt;
      b_type          r;
      r  = s;
      bt = {s.brem, s.bdq[QM_W-1]};
      if (bt >= {1'b0, s.bden}) begin
         r.brem = DEN_W'(bt - {1'b0, s.bden});
         r.bdq  = {s.bdq[QM_W-2:0], 1'b1};
      end else begin
         r.brem = bt[DEN_W-1:0];
         r.bdq  = {s.bdq[QM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic c_type c_step(c_type s, logic [KT_W-1:0] kmag);
      logic [KT_W:0] ct;
      c_type         r;
      r  = s;
      ct = {s.crem, s.cdq[TN_W-1]};
      if (ct >= {1'b0, kmag}) begin
         r.crem = KT_W'(ct - {1'b0, kmag});
         r.cdq  = {s.cdq[TN_W-2:0], 1'b1};
      end else begin
         r.crem = ct[KT_W-1:0];
         r.cdq  = {s.cdq[TN_W-2:0], 1'b0};
      end
      return r;
   endfunction

   a_type  a_ff [0:VART_W];
   b_type  b_ff [0:QM_W];
   c_type  c_ff [0:TN_W];
   m1_type m1_ff;
   m2_type m2_ff;
   t1_type t1_ff;
   t2_type t2_ff;
   e_type  e1_ff, e2_ff, e3_ff;
   result_type e4_ff;
   logic [LAT-1:0] vld_ff;

   a_type  a_in;
   m1_type m1_in;
   m2_type m2_in;
   b_type  b_in;
   t1_type t1_in;
   t2_type t2_in;
   c_type  c_in;
   e_type  e1_in, e2_in, e3_in;
   result_type e4_in;

   logic [SLP_W-1:0] slope_mag;
   logic [KV_W-1:0]  kv, kv_mag;
   logic [KT_W-1:0]  kt, kt_mag;

   assign kv        = cfg.kv_kt[15:10];
   assign kt        = cfg.kv_kt[9:0];
   assign kv_mag    = kv[KV_W-1] ? KV_W'(-kv) : kv;
   assign kt_mag    = kt[KT_W-1] ? KT_W'(-kt) : kt;
   assign slope_mag = cfg.slope[15] ? SLP_W'(-cfg.slope) : cfg.slope;

   always_comb begin
      logic signed [23:0] ptat_x;
      logic signed [23:0] vbe_x;
      logic signed [23:0] d2;
      logic [16:0]        sdiff;
      logic [15:0]        sdiff_mag;
      logic [15:0]        ptat_mag;
      logic [D2_W-1:0]    d2_mag;
      ptat_x    = {{8{in_ptat[15]}}, in_ptat};
      vbe_x     = {{8{in_vbe[15]}}, in_vbe};
      d2        = ptat_x * $signed(24'(cfg.alpha) + 24'd32) + (vbe_x <<< 2);
      sdiff     = {in_supply[15], in_supply} - {cfg.supply25[15], cfg.supply25};
      sdiff_mag = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
      ptat_mag  = in_ptat[15] ? 16'(-in_ptat) : in_ptat;
      d2_mag    = d2[23] ? D2_W'(-d2) : D2_W'(d2);
      a_in.err  = (cfg.slope == '0) || (kt == '0) || (d2 == '0);
      a_in.vneg = in_ptat[15] ^ d2[23];
      a_in.dneg = sdiff[16] ^ cfg.slope[15];
      a_in.vrem = '0;
      a_in.vdq  = {ptat_mag, {(VART_W-16){1'b0}}};
      a_in.vden = d2_mag;
      a_in.drem = '0;
      a_in.ddq  = {sdiff_mag, {FRAC_BITS{1'b0}}};
   end

   always_comb begin
      m1_in.err  = a_ff[VART_W].err;
      m1_in.vneg = a_ff[VART_W].vneg;
      m1_in.vmag = a_ff[VART_W].vdq;
      m1_in.pneg = a_ff[VART_W].dneg ^ kv[KV_W-1];
      m1_in.pmag = (DV_W+KV_W)'(a_ff[VART_W].ddq) * (DV_W+KV_W)'(kv_mag);
   end

   always_comb begin
      logic [DEN_W:0] shv;
      shv        = (DEN_W+1)'(m1_ff.pmag >> 12);
      m2_in.err  = m1_ff.err;
      m2_in.vneg = m1_ff.vneg;
      m2_in.vmag = m1_ff.vmag;
      m2_in.den  = ONE_DEN + (m1_ff.pneg ? -shv : shv);
   end

   always_comb begin
      logic [DEN_W-1:0] dmag;
      dmag      = m2_ff.den[DEN_W] ? DEN_W'(-m2_ff.den) : m2_ff.den[DEN_W-1:0];
      b_in.err  = m2_ff.err || (m2_ff.den == '0);
      b_in.qneg = m2_ff.vneg ^ m2_ff.den[DEN_W];
      b_in.ovf  = m2_ff.vmag >= (VART_W'(dmag) << 24);
      b_in.brem = DEN_W'(m2_ff.vmag >> 24);
      b_in.bdq  = {m2_ff.vmag[23:0], {FRAC_BITS{1'b0}}};
      b_in.bden = dmag;
   end

   always_comb begin
      logic [Q_SW-1:0] qm;
      qm = b_ff[QM_W].ovf ? (Q_SW'(1) << QM_W) : Q_SW'(b_ff[QM_W].bdq);
      t1_in.err = b_ff[QM_W].err;
      t1_in.qs  = b_ff[QM_W].qneg ? -qm : qm;
   end

   always_comb begin
      t2_in.err = t1_ff.err;
      t2_in.t   = {t1_ff.qs[Q_SW-1], t1_ff.qs}
                  - (T_SW'($signed(cfg.ptat25)) << FRAC_BITS);
   end

   always_comb begin
      logic [T_SW-1:0] tm;
      tm        = t2_ff.t[T_SW-1] ? -t2_ff.t : t2_ff.t;
      c_in.err  = t2_ff.err;
      c_in.cneg = t2_ff.t[T_SW-1] ^ kt[KT_W-1];
      c_in.crem = '0;
      c_in.cdq  = {tm[T_SW-2:0], 3'b000};
   end

   always_comb begin
      logic [TOT_W-1:0] qv;
      qv        = TOT_W'(c_ff[TN_W].cdq);
      e1_in.err = c_ff[TN_W].err;
      e1_in.v   = c_ff[TN_W].cneg ? -qv : qv;
   end

   always_comb begin
      e2_in.err = e1_ff.err;
      e2_in.v   = e1_ff.v + (TOT_W'(cfg.base) << FRAC_BITS);
   end

   always_comb begin
      logic [TOT_W-1:0] sum;
      sum       = e2_ff.v + (e2_ff.v[TOT_W-1] ? RND : '0);
      e3_in.err = e2_ff.err;
      e3_in.v   = TOT_W'($signed(sum) >>> (FRAC_BITS - 8));
   end

   always_comb begin
      logic signed [TOT_W-1:0] res;
      logic [TEMP_W-1:0]       sat;
      logic                    flag;
      res = $signed(e3_ff.v);
      if (res > RES_MAX) begin
         sat  = TEMP_W'(TEMP_MAX);
         flag = 1'b1;
      end else if (res < RES_MIN) begin
         sat  = TEMP_W'(TEMP_MIN);
         flag = 1'b1;
      end else begin
         sat  = res[TEMP_W-1:0];
         flag = 1'b0;
      end
      e4_in.temp = e3_ff.err ? '0 : sat;
      e4_in.err  = e3_ff.err | flag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= a_in;
         for (int k = 0; k < VART_W; k++) begin
            a_ff[k+1] <= a_step(a_ff[k], k < DV_W, slope_mag);
         end
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         b_ff[0] <= b_in;
         for (int k = 0; k < QM_W; k++) begin
            b_ff[k+1] <= b_step(b_ff[k]);
         end
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         c_ff[0] <= c_in;
         for (int k = 0; k < TN_W; k++) begin
            c_ff[k+1] <= c_step(c_ff[k], kt_mag);
         end
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         e3_ff <= e3_in;
         e4_ff <= e4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_res   = e4_ff;

endmodule

/* dv/ptat_ambient_temperature_tb.sv */
// Testbench for ptat_ambient_temperature: directed table, then random beats checked
// against a fixed-point predictor of the ambient temperature calculation.
// Depends on ptatamb_pkg and the ptat_ambient_temperature RTL.
module ptat_ambient_temperature_tb
   import ptatamb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      int          cfg_sel;
      logic [15:0] supply;
      logic [15:0] ptat;
      logic [15:0] vbe;
      bit          known;
      logic [17:0] temp;
      bit          err;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_calc_error;
   logic signed [IN_W-1:0] req_supply_raw, req_ptat_raw, req_vbe_raw;
   logic signed [TEMP_W-1:0] rsp_ambient_temp;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   result_type temp_queue[$];
   cfg_type cur_cfg;
   cfg_type cfg_set[6];
   row_type rows[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_req = 0;
   bit failed = 0;

   ptat_ambient_temperature uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic result_type predict_temp(cfg_type c, logic signed [15:0] s,
                                               logic signed [15:0] p, logic signed [15:0] v);
      longint one, kv, kt, slope, s25, p25, nib, base, d2, dv, den1;
      longint vart, ip, rm, q, t, tot, res, qlim;
      bit err;
      result_type r;
      one = longint'(1) <<< FRAC_BITS;
      qlim = longint'(1) <<< 24;
      kv = $signed(c.kv_kt[15:10]);
      kt = $signed(c.kv_kt[9:0]);
      slope = $signed(c.slope);
      s25 = $signed(c.supply25);
      p25 = $signed(c.ptat25);
      nib = c.alpha;
      base = c.base;
      res = 0;
      d2 = longint'(p) * (nib + 32) + 4 * longint'(v);
      err = (slope == 0 || kt == 0 || d2 == 0);
      if (!err) begin
         dv = (longint'(s) - s25) * one / slope;
         den1 = one + (kv * dv) / 4096;
         if (den1 == 0) err = 1;
      end
      if (!err) begin
         vart = longint'(p) * (longint'(1) <<< (20 + FRAC_BITS)) / d2;
         ip = vart / den1;
         rm = vart % den1;
         if (ip >= qlim) q = qlim * one;
         else if (ip <= -qlim) q = -qlim * one;
         else q = ip * one + (rm * one) / den1;
         t = q - p25 * one;
         tot = (t * 8) / kt + base * one;
         res = tot / (longint'(1) <<< (FRAC_BITS - 8));
         if (res > TEMP_MAX) begin
            res = TEMP_MAX;
            err = 1;
         end else if (res < TEMP_MIN) begin
            res = TEMP_MIN;
            err = 1;
         end
      end
      r.temp = res[17:0];
      r.err = err;
      return r;
   endfunction

   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      @(negedge clock);
      psel = 1;
      pwrite = 1;
      penable = 0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   // Called at a falling edge, right after the last beat was taken.
   task automatic apply_cfg(cfg_type c);
      req_valid = 0;
      while (temp_queue.size() != 0) @(posedge clock);
      repeat (200) @(negedge clock);
      csr_write(REG_KV_KT, 32'(c.kv_kt));
      csr_write(REG_PTAT25, 32'(c.ptat25));
      csr_write(REG_ALPHA, 32'(c.alpha));
      csr_write(REG_SUPPLY25, 32'(c.supply25));
      csr_write(REG_SLOPE, 32'(c.slope));
      csr_write(REG_BASE, 32'(c.base));
      cur_cfg = c;
   endtask

   // Called at a falling edge; returns at a falling edge, once a rising edge has taken the beat.
   task automatic send_beat(logic [15:0] s, logic [15:0] p, logic [15:0] v,
                            bit known, result_type want);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_supply_raw = s;
      req_ptat_raw = p;
      req_vbe_raw = v;
      do @(posedge clock); while (req_stall);
      r = predict_temp(cur_cfg, s, p, v);
      if (known && r != want) begin
         failed = 1;
         $display("table row disagrees with predictor: %h vs %h", want, r);
      end
      temp_queue.push_back(r);
      @(negedge clock);
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.kv_kt = 16'($urandom);
      c.ptat25 = ($urandom_range(3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(4000) - 2000);
      c.alpha = 4'($urandom);
      c.supply25 = 16'($urandom);
      c.slope = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
      c.base = BASE_W'($urandom);
      return c;
   endfunction

   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_stall = 1;
            repeat (400) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (temp_queue.size() == 0) begin
            failed = 1;
            if (mismatches < 10) $display("unexpected result beat %h", rsp_ambient_temp);
            mismatches++;
         end else begin
            want = temp_queue.pop_front();
            if (rsp_ambient_temp !== want.temp || rsp_calc_error !== want.err) begin
               failed = 1;
               if (mismatches < 10)
                  $display("mismatch: expected temp %h err %b, got temp %h err %b",
                           want.temp, want.err, rsp_ambient_temp, rsp_calc_error);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int prev_sel, count, m;
      logic [15:0] s, p, v;
      result_type want;
      reset = 1;
      req_valid = 0;
      req_supply_raw = 0;
      req_ptat_raw = 0;
      req_vbe_raw = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;

      cfg_set[0] = '{kv_kt: 16'h0000, ptat25: 16'h0000, alpha: 4'h0, supply25: 16'h0000,
                     slope: 16'h0001, base: 6'd25};
      cfg_set[1] = '{kv_kt: {6'd2, 10'd100}, ptat25: 16'd1000, alpha: 4'd5,
                     supply25: -16'sd1000, slope: 16'd200, base: 6'd25};
      cfg_set[2] = '{kv_kt: 16'h8001, ptat25: 16'h0000, alpha: 4'h0, supply25: 16'h0000,
                     slope: 16'h0001, base: 6'd0};
      cfg_set[3] = cfg_set[1];
      cfg_set[3].slope = 0;
      cfg_set[4] = '{kv_kt: 16'hFFFF, ptat25: 16'h7FFF, alpha: 4'hF, supply25: 16'h7FFF,
                     slope: 16'h7FFF, base: 6'd63};
      cfg_set[5] = '{kv_kt: 16'h8200, ptat25: 16'h8000, alpha: 4'h0, supply25: 16'h8000,
                     slope: 16'h8000, base: 6'd0};
      cur_cfg = cfg_set[0];

      rows = '{
         '{0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 18'h0, 1},
         '{0, 16'h8000, 16'h8000, 16'h8000, 1, 18'h0, 1},
         '{0, 16'h0000, 16'h1000, 16'h0100, 1, 18'h0, 1},
         '{1, 16'h0000, 16'h0000, 16'h0000, 1, 18'h0, 1},
         '{1, 16'hFC18, 16'd3000, 16'd2000, 0, 18'h0, 0},
         '{1, 16'h0000, 16'd1500, 16'hF000, 0, 18'h0, 0},
         '{1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 18'h0, 0},
         '{1, 16'h8000, 16'h8000, 16'h8000, 0, 18'h0, 0},
         '{1, 16'h0000, 16'd4, 16'hFFD5, 0, 18'h0, 0},
         '{1, 16'h1234, 16'hFF00, 16'h0200, 0, 18'h0, 0},
         '{2, 16'd128, 16'd100, 16'd0, 1, 18'h0, 1},
         '{2, 16'd64, 16'd100, 16'd0, 0, 18'h0, 0},
         '{3, 16'd500, 16'd3000, 16'd2000, 1, 18'h0, 1},
         '{4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 18'h0, 0},
         '{4, 16'h8000, 16'h8000, 16'h8000, 0, 18'h0, 0},
         '{4, 16'h0000, 16'h0001, 16'h0000, 0, 18'h0, 0},
         '{5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 18'h0, 0},
         '{5, 16'h8000, 16'h8000, 16'h8000, 0, 18'h0, 0},
         '{5, 16'h0000, 16'hFFFF, 16'h0001, 0, 18'h0, 0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      prev_sel = 0;
      foreach (rows[i]) begin
         if (rows[i].cfg_sel != prev_sel) begin
            apply_cfg(cfg_set[rows[i].cfg_sel]);
            prev_sel = rows[i].cfg_sel;
         end
         want.temp = rows[i].temp;
         want.err = rows[i].err;
         send_beat(rows[i].supply, rows[i].ptat, rows[i].vbe, rows[i].known, want);
      end

      count = 0;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 1) apply_cfg(cfg_set[4]);
         else if (ph == 2) apply_cfg(cfg_set[5]);
         else if (ph == 0) apply_cfg(cfg_set[1]);
         else apply_cfg(random_cfg());
         if (ph == 3) hold_req = 1;
         for (int k = 0; k < 220; k++) begin
            if (count < 585) begin
               send_idle_pct = 14;
               recv_idle_pct = 74;
            end else if (count < 1170) begin
               send_idle_pct = 74;
               recv_idle_pct = 14;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            case ($urandom_range(7))
               0, 1: begin
                  s = 16'($urandom);
                  p = 16'($urandom);
                  v = 16'($urandom);
               end
               2: begin
                  m = $urandom_range(200, 1);
                  if ($urandom_range(1)) m = -m;
                  s = 16'($urandom);
                  p = 16'(4 * m);
                  v = 16'(-m * (int'(cur_cfg.alpha) + 32));
               end
               default: begin
                  s = 16'(int'(cur_cfg.supply25) + int'($urandom_range(4000)) - 2000);
                  p = 16'($urandom_range(20000, 500));
                  v = 16'(int'($urandom_range(30000)) - 15000);
               end
            endcase
            send_beat(s, p, v, 0, want);
            count++;
         end
      end

      req_valid = 0;
      while (temp_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && temp_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
